/* hw/rtl/lsc_pkg.sv */
// Shared constants, register codes and helpers for the line segment clipper.
// Used by every module of the block; depends on nothing.
`default_nettype none
package lsc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_IDX_W       = 2;

  localparam int WIN_MIN_RST = 100;
  localparam int WIN_MAX_RST = 300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } reg_idx_t;

  // Bits of one classified segment as it sits in the queue.
  function automatic int entry_width(input int cw);
    return 2 * cw + 2 * (cw + 1) + 9 + 8 * (cw + 1);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/lsc_front.sv */
// Front end: window registers and per-edge classification.
// Depends on lsc_pkg; feeds lsc_queue.
`default_nettype none
module lsc_front #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF,
  parameter int QW          = lsc_pkg::entry_width(lsc_pkg::COORD_WIDTH_DEF)
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire [lsc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire [COORD_WIDTH-1:0]       cfg_wdata,
  input  wire [4*COORD_WIDTH-1:0]     seg,
  output logic [QW-1:0]               entry
);
  localparam int CW = COORD_WIDTH;

  typedef struct packed {
    logic signed [CW-1:0]  xa;
    logic signed [CW-1:0]  ya;
    logic signed [CW:0]    dx;
    logic signed [CW:0]    dy;
    logic                  pre_rej;
    logic [3:0]            en_role;
    logic [3:0]            ex_role;
    logic [3:0][CW:0]      pm;
    logic [3:0][CW:0]      qm;
  } entry_t;

  logic signed [CW-1:0] xmin_r, xmax_r, ymin_r, ymax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r <= CW'(lsc_pkg::WIN_MIN_RST);
      xmax_r <= CW'(lsc_pkg::WIN_MAX_RST);
      ymin_r <= CW'(lsc_pkg::WIN_MIN_RST);
      ymax_r <= CW'(lsc_pkg::WIN_MAX_RST);
    end else if (cfg_we) begin
      unique case (lsc_pkg::reg_idx_t'(cfg_idx))
        lsc_pkg::REG_X_MIN: xmin_r <= cfg_wdata;
        lsc_pkg::REG_X_MAX: xmax_r <= cfg_wdata;
        lsc_pkg::REG_Y_MIN: ymin_r <= cfg_wdata;
        lsc_pkg::REG_Y_MAX: ymax_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] xa, ya, xb, yb;
  logic signed [CW:0]   p [4];
  logic signed [CW:0]   q [4];
  entry_t e;

  assign xa = seg[CW-1:0];
  assign ya = seg[2*CW-1:CW];
  assign xb = seg[3*CW-1:2*CW];
  assign yb = seg[4*CW-1:3*CW];

  always_comb begin
    e.xa = xa;
    e.ya = ya;
    e.dx = (CW+1)'(xb) - (CW+1)'(xa);
    e.dy = (CW+1)'(yb) - (CW+1)'(ya);
    p[0] = -e.dx;
    q[0] = (CW+1)'(xa) - (CW+1)'(xmin_r);
    p[1] = e.dx;
    q[1] = (CW+1)'(xmax_r) - (CW+1)'(xa);
    p[2] = -e.dy;
    q[2] = (CW+1)'(ya) - (CW+1)'(ymin_r);
    p[3] = e.dy;
    q[3] = (CW+1)'(ymax_r) - (CW+1)'(ya);
    e.pre_rej = 1'b0;
    for (int k = 0; k < 4; k++) begin
      e.pm[k] = p[k][CW] ? -p[k] : p[k];
      e.qm[k] = q[k][CW] ? -q[k] : q[k];
      // Outside a parallel edge, or leaving before the segment starts.
      if (q[k][CW] && !p[k][CW]) e.pre_rej = 1'b1;
      e.en_role[k] = p[k][CW] && q[k][CW];
      e.ex_role[k] = !p[k][CW] && (p[k] != '0) && !q[k][CW];
    end
  end

  assign entry = e;

endmodule
`default_nettype wire

/* hw/rtl/lsc_queue.sv */
// Short FIFO between the classifier and the divide/multiply pipeline.
// Depends on lsc_pkg for its depth.
`default_nettype none
module lsc_queue #(
  parameter int QW = lsc_pkg::entry_width(lsc_pkg::COORD_WIDTH_DEF)
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           wr_en,
  input  wire [QW-1:0]  wr_data,
  output logic          full,
  input  wire           rd_en,
  output logic          nonempty,
  output logic [QW-1:0] rd_data
);
  localparam int D  = lsc_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  logic [QW-1:0] mem_r [D];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_wr, do_rd;

  assign full     = (cnt_r == (AW+1)'(D));
  assign nonempty = (cnt_r != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/lsc_back.sv */
// Back end: four pipelined ratio dividers, entry/exit selection and endpoints.
// Depends on lsc_pkg; takes entries from lsc_queue.
`default_nettype none
module lsc_back #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = lsc_pkg::T_FRAC_BITS_DEF,
  parameter int QW          = lsc_pkg::entry_width(lsc_pkg::COORD_WIDTH_DEF)
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       q_vld,
  input  wire [QW-1:0]              q_data,
  output logic                      q_pop,
  output logic                      res_vld,
  input  wire                       res_rdy,
  output logic [4*COORD_WIDTH:0]    res
);
  localparam int CW = COORD_WIDTH;
  localparam int F  = T_FRAC_BITS;
  localparam int NS = F + 1;
  localparam int TW = F + 2;
  localparam int MW = CW + 1 + TW;

  typedef struct packed {
    logic signed [CW-1:0]  xa;
    logic signed [CW-1:0]  ya;
    logic signed [CW:0]    dx;
    logic signed [CW:0]    dy;
    logic                  pre_rej;
    logic [3:0]            en_role;
    logic [3:0]            ex_role;
    logic [3:0][CW:0]      pm;
    logic [3:0][CW:0]      qm;
  } entry_t;

  typedef struct packed {
    logic signed [CW-1:0]  xa;
    logic signed [CW-1:0]  ya;
    logic signed [CW:0]    dx;
    logic signed [CW:0]    dy;
    logic                  pre_rej;
    logic [3:0]            en_role;
    logic [3:0]            ex_role;
    logic [3:0][CW:0]      pm;
    logic [3:0][CW+1:0]    rem;
    logic [3:0][F:0]       quo;
    logic [3:0]            sat;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0]  xa;
    logic signed [CW-1:0]  ya;
    logic signed [CW:0]    dx;
    logic signed [CW:0]    dy;
    logic                  rej;
    logic [TW-1:0]         t_en;
    logic [TW-1:0]         t_ex;
  } sel_t;

  typedef struct packed {
    logic signed [CW-1:0]  xa;
    logic signed [CW-1:0]  ya;
    logic                  sx;
    logic                  sy;
    logic                  rej;
    logic [3:0][MW-1:0]    prod;
  } mul_t;

  localparam logic [TW-1:0] T_ONE = TW'(1) << F;

  logic  en;
  entry_t qe;
  div_t  dv_r   [NS+1];
  div_t  dv_nxt [NS+1];
  logic  dv_vld_r [NS+1];
  sel_t  sl_r, sl_nxt;
  logic  sl_vld_r;
  mul_t  ml_r, ml_nxt;
  logic  ml_vld_r;
  logic  [4*CW:0] out_r, out_nxt;
  logic  out_vld_r;

  // Everything advances together; a waiting result holds the whole pipeline.
  assign en      = !out_vld_r || res_rdy;
  assign q_pop   = en;
  assign qe      = q_data;
  assign res_vld = out_vld_r;
  assign res     = out_r;

  always_comb begin
    logic [CW+1:0] r;
    logic          ge;
    dv_nxt[0].xa      = qe.xa;
    dv_nxt[0].ya      = qe.ya;
    dv_nxt[0].dx      = qe.dx;
    dv_nxt[0].dy      = qe.dy;
    dv_nxt[0].pre_rej = qe.pre_rej;
    dv_nxt[0].en_role = qe.en_role;
    dv_nxt[0].ex_role = qe.ex_role;
    dv_nxt[0].pm      = qe.pm;
    for (int k = 0; k < 4; k++) begin
      dv_nxt[0].rem[k] = (CW+2)'(qe.qm[k]);
      dv_nxt[0].quo[k] = '0;
      // A quotient of two or more is past either cap.
      dv_nxt[0].sat[k] = {1'b0, qe.qm[k]} >= {qe.pm[k], 1'b0};
    end
    for (int j = 0; j < NS; j++) begin
      dv_nxt[j+1] = dv_r[j];
      for (int k = 0; k < 4; k++) begin
        r  = (j == 0) ? dv_r[j].rem[k] : {dv_r[j].rem[k][CW:0], 1'b0};
        ge = r >= {1'b0, dv_r[j].pm[k]};
        dv_nxt[j+1].rem[k] = ge ? r - {1'b0, dv_r[j].pm[k]} : r;
        dv_nxt[j+1].quo[k] = {dv_r[j].quo[k][F-1:0], ge};
      end
    end
  end

  always_comb begin
    logic [TW-1:0] re, rx;
    div_t d;
    d = dv_r[NS];
    sl_nxt.xa   = d.xa;
    sl_nxt.ya   = d.ya;
    sl_nxt.dx   = d.dx;
    sl_nxt.dy   = d.dy;
    sl_nxt.t_en = '0;
    sl_nxt.t_ex = T_ONE;
    for (int k = 0; k < 4; k++) begin
      re = (d.sat[k] || (TW'(d.quo[k]) > T_ONE + 1'b1)) ? T_ONE + 1'b1 : TW'(d.quo[k]);
      rx = (d.sat[k] || (TW'(d.quo[k]) > T_ONE)) ? T_ONE : TW'(d.quo[k]);
      if (d.en_role[k] && re > sl_nxt.t_en) sl_nxt.t_en = re;
      if (d.ex_role[k] && rx < sl_nxt.t_ex) sl_nxt.t_ex = rx;
    end
    sl_nxt.rej = d.pre_rej || (sl_nxt.t_en > sl_nxt.t_ex);
  end

  always_comb begin
    logic [CW:0] mx, my;
    mx = sl_r.dx[CW] ? -sl_r.dx : sl_r.dx;
    my = sl_r.dy[CW] ? -sl_r.dy : sl_r.dy;
    ml_nxt.xa      = sl_r.xa;
    ml_nxt.ya      = sl_r.ya;
    ml_nxt.sx      = sl_r.dx[CW];
    ml_nxt.sy      = sl_r.dy[CW];
    ml_nxt.rej     = sl_r.rej;
    ml_nxt.prod[0] = MW'(mx) * MW'(sl_r.t_en);
    ml_nxt.prod[1] = MW'(my) * MW'(sl_r.t_en);
    ml_nxt.prod[2] = MW'(mx) * MW'(sl_r.t_ex);
    ml_nxt.prod[3] = MW'(my) * MW'(sl_r.t_ex);
  end

  always_comb begin
    logic [CW-1:0] m0, m1, m2, m3, x0, y0, x1, y1;
    m0 = ml_r.prod[0][F+CW-1:F];
    m1 = ml_r.prod[1][F+CW-1:F];
    m2 = ml_r.prod[2][F+CW-1:F];
    m3 = ml_r.prod[3][F+CW-1:F];
    x0 = ml_r.sx ? ml_r.xa - m0 : ml_r.xa + m0;
    y0 = ml_r.sy ? ml_r.ya - m1 : ml_r.ya + m1;
    x1 = ml_r.sx ? ml_r.xa - m2 : ml_r.xa + m2;
    y1 = ml_r.sy ? ml_r.ya - m3 : ml_r.ya + m3;
    out_nxt = ml_r.rej ? '0 : {y1, x1, y0, x0, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j <= NS; j++) dv_r[j] <= dv_nxt[j];
      sl_r  <= sl_nxt;
      ml_r  <= ml_nxt;
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NS; j++) dv_vld_r[j] <= 1'b0;
      sl_vld_r  <= 1'b0;
      ml_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= q_vld;
      for (int j = 0; j < NS; j++) dv_vld_r[j+1] <= dv_vld_r[j];
      sl_vld_r  <= dv_vld_r[NS];
      ml_vld_r  <= sl_vld_r;
      out_vld_r <= ml_vld_r;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/line_segment_clip_top.sv */
// Top level of the Liang-Barsky line segment clipper.
// Depends on lsc_pkg, lsc_front, lsc_queue and lsc_back.
//
//   channel | direction | handshake          | payload
//   in_     | slave     | tvalid/tready      | tdata: start_x, start_y, end_x, end_y
//   out_    | master    | tvalid/tready      | tdata: visible, clip_x0/y0/x1/y1
//   cfg_    | write     | cfg_we             | cfg_idx, cfg_wdata
//
// One segment per cycle sustained while out_tready stays high. An accepted in_
// beat reaches out_tvalid through the queue entry, the pop into the first
// divider stage, T_FRAC_BITS + 1 divide steps (one quotient bit a stage),
// then the select, multiply and output registers.
// Reset clears all valid state; the window registers return to 100/300.
// A stalled output holds the back pipeline; the four-entry queue absorbs beats
// until it fills, then in_tready drops.
`default_nettype none
module line_segment_clip_top #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = lsc_pkg::T_FRAC_BITS_DEF,
  localparam int IN_W       = ((4 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W      = ((4 * COORD_WIDTH + 1 + 7) / 8) * 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // start_x, start_y, end_x, end_y from bit 0 up
  input  wire [IN_W-1:0]               in_tdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // visible, clip_x0, clip_y0, clip_x1, clip_y1 from bit 0 up
  output logic [OUT_W-1:0]             out_tdata,
  input  wire                          cfg_we,
  input  wire [lsc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire [COORD_WIDTH-1:0]        cfg_wdata
);
  localparam int QW    = lsc_pkg::entry_width(COORD_WIDTH);

  logic [QW-1:0]          f_entry, q_head;
  logic                   q_full, q_nonempty, q_pop;
  logic                   res_vld;
  logic [4*COORD_WIDTH:0] res;

  assign in_tready = !q_full;

  lsc_front #(.COORD_WIDTH(COORD_WIDTH), .QW(QW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .seg(in_tdata[4*COORD_WIDTH-1:0]),
    .entry(f_entry)
  );

  lsc_queue #(.QW(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_en(in_tvalid), .wr_data(f_entry), .full(q_full),
    .rd_en(q_pop), .nonempty(q_nonempty), .rd_data(q_head)
  );

  lsc_back #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS), .QW(QW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_vld(q_nonempty), .q_data(q_head), .q_pop(q_pop),
    .res_vld(res_vld), .res_rdy(out_tready), .res(res)
  );

  assign out_tvalid = res_vld;
  assign out_tdata  = OUT_W'(res);

endmodule
`default_nettype wire
